// ----- hdl/vcdg_pkg.sv -----
// Shared constants, types and helpers of the volume gradient block.
package vcdg_pkg;

    localparam int MAX_WIDTH      = 256;
    localparam int MAX_HEIGHT     = 256;
    localparam int MAX_DEPTH      = 1024;
    localparam int SAMPLE_BITS    = 16;

    localparam int X_BITS         = $clog2(MAX_WIDTH);
    localparam int Y_BITS         = $clog2(MAX_HEIGHT);
    localparam int Z_BITS         = $clog2(MAX_DEPTH);
    localparam int WIDTH_CFG_BITS = 9;
    localparam int DEPTH_CFG_BITS = 11;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int GRAD_BITS      = SAMPLE_BITS + 1;

    // Each RAM holds the rows of one parity; a word packs one voxel of both planes.
    localparam int RAM_DEPTH      = MAX_WIDTH * MAX_HEIGHT / 2;
    localparam int RAM_ADDR_BITS  = $clog2(RAM_DEPTH);
    localparam int WORD_BITS      = 2 * SAMPLE_BITS;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEPTH  = 2'd2;

    // Item waiting for its RAM read data.
    typedef struct packed {
        logic                   wr;
        logic [X_BITS-1:0]      x;
        logic [Y_BITS-1:0]      y;
        logic [Z_BITS-1:0]      z;
        logic                   last;
        logic                   has_mx;
        logic                   has_px;
        logic                   has_my;
        logic                   has_py;
        logic                   has_mz;
        logic [SAMPLE_BITS-1:0] pz;
    } s1_item_t;

    // Picks the sample of one plane parity out of a packed word.
    function automatic logic [SAMPLE_BITS-1:0] plane_half(input logic [WORD_BITS-1:0] word,
                                                          input logic sel);
        logic [SAMPLE_BITS-1:0] res;
        res = sel ? word[WORD_BITS-1:SAMPLE_BITS] : word[SAMPLE_BITS-1:0];
        return res;
    endfunction

endpackage

// ----- hdl/vcdg_ram.sv -----
// Generic RAM with one write port and two registered read ports, read-first.
module vcdg_ram #(
    parameter int  WIDTH     = 32,
    parameter int  DEPTH     = 1024,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr_a,
    input  logic [ADDR_BITS-1:0] raddr_b,
    output logic [WIDTH-1:0]     rdata_a,
    output logic [WIDTH-1:0]     rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- hdl/volume_central_difference_gradient.sv -----
// Top level of the streaming 3-D central-difference gradient block.
//
// Voxel samples arrive in raster order (x fastest, then y, then z) and the block returns,
// for each voxel, twice its central-difference gradient on x, y and z together with the
// voxel position; neighbors outside the volume count as zero. The result for a voxel
// leaves when the sample one plane further on is pushed, and drain items take out the
// results of the final plane once the whole volume is in. The block takes one item per
// clock cycle unless the output stalls; results pass the read stage and output registers.
// Two planes are kept in two 32768 x 32 RAMs, split by row parity, where each word holds
// the same voxel of both planes. Per item the RAM of the voxel's own row parity is read
// at the voxel and its right neighbor, the other RAM at the rows above and below, and the
// word of the voxel is written back with the new sample in the older plane's half; the
// left neighbor is the center of the previous item. A write-back and the read of the next
// item may meet on one word, and the read data is then forwarded. Configuration writes
// restart the volume; the user must make them while the block is idle (not enforced).
module volume_central_difference_gradient import vcdg_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [SAMPLE_BITS-1:0]        s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [GRAD_BITS-1:0]   m_grad_x,
    output logic signed [GRAD_BITS-1:0]   m_grad_y,
    output logic signed [GRAD_BITS-1:0]   m_grad_z,
    output logic [X_BITS-1:0]             m_pos_x,
    output logic [Y_BITS-1:0]             m_pos_y,
    output logic [Z_BITS-1:0]             m_pos_z,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int GLOB_BITS = RAM_ADDR_BITS + 1;

    // Configuration, already clamped to the usable range.
    logic [WIDTH_CFG_BITS-1:0] width_reg, height_reg;
    logic [DEPTH_CFG_BITS-1:0] depth_reg;

    // Input and output voxel counters.
    logic [X_BITS-1:0] in_x_reg, out_x_reg;
    logic [Y_BITS-1:0] in_y_reg, out_y_reg;
    logic [Z_BITS-1:0] in_z_reg, out_z_reg;
    logic              in_done_reg;

    // Read stage.
    logic                   s1_valid_reg;
    s1_item_t               s1_reg;
    s1_item_t               s1_next;
    logic [3:0]             fwd_hit_reg, fwd_hit_next;
    logic [WORD_BITS-1:0]   fwd_word_reg;
    logic [SAMPLE_BITS-1:0] prev_center_reg;

    // Output register.
    logic                   m_valid_reg;
    logic [GRAD_BITS-1:0]   m_grad_x_reg, m_grad_y_reg, m_grad_z_reg;
    logic [X_BITS-1:0]      m_pos_x_reg;
    logic [Y_BITS-1:0]      m_pos_y_reg;
    logic [Z_BITS-1:0]      m_pos_z_reg;
    logic                   m_last_reg;

    logic accept, is_push, push_ok, drain_ok, gives_out, direct_we, out_free;
    logic s1_advance, wb_we, cfg_hit;
    logic in_x_last, in_y_last, in_z_last, out_x_last, out_y_last, out_z_last, out_end;

    logic [X_BITS-1:0]        ax;
    logic [Y_BITS-1:0]        ym1, yp1;
    logic [RAM_ADDR_BITS-1:0] addr_a, addr_b, addr_c, addr_d;
    logic [GLOB_BITS-1:0]     wb_glob;

    logic                     ram_we, ram_sel;
    logic [RAM_ADDR_BITS-1:0] ram_waddr;
    logic [WORD_BITS-1:0]     ram_wdata, wb_word;
    logic [WORD_BITS-1:0]     r0a, r0b, r1a, r1b;
    logic [WORD_BITS-1:0]     w_a, w_b, w_c, w_d;

    logic [SAMPLE_BITS-1:0]   px, mx, py, my, mz, center;
    logic [GRAD_BITS-1:0]     gx, gy, gz;

    logic [WIDTH_CFG_BITS-1:0] cfg_w9;
    logic [DEPTH_CFG_BITS-1:0] cfg_d11;

    // Handshakes. The read stage only ever holds items that produce a result.
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_ready    = !s1_valid_reg || out_free;
    assign cfg_ready  = 1'b1;
    assign cfg_hit    = cfg_valid && cfg_ready;

    // Item decode. Pushes past the end of the volume and drains before it is complete
    // are dropped without a trace.
    assign is_push   = (s_operation == OP_PUSH);
    assign push_ok   = is_push && !in_done_reg;
    assign drain_ok  = (s_operation == OP_DRAIN) && in_done_reg;
    assign gives_out = (push_ok && (in_z_reg != '0)) || drain_ok;
    assign direct_we = accept && push_ok && (in_z_reg == '0);
    assign wb_we     = s1_advance && s1_reg.wr;

    assign in_x_last  = ({1'b0, in_x_reg} == width_reg - WIDTH_CFG_BITS'(1));
    assign in_y_last  = ({1'b0, in_y_reg} == height_reg - WIDTH_CFG_BITS'(1));
    assign in_z_last  = ({1'b0, in_z_reg} == depth_reg - DEPTH_CFG_BITS'(1));
    assign out_x_last = ({1'b0, out_x_reg} == width_reg - WIDTH_CFG_BITS'(1));
    assign out_y_last = ({1'b0, out_y_reg} == height_reg - WIDTH_CFG_BITS'(1));
    assign out_z_last = ({1'b0, out_z_reg} == depth_reg - DEPTH_CFG_BITS'(1));
    assign out_end    = out_x_last && out_y_last && out_z_last;

    // Read addresses of the voxel being output. The right neighbor and the rows above and
    // below may fall outside the volume at its edges; those values are masked later.
    assign ax     = out_x_reg + X_BITS'(1);
    assign ym1    = out_y_reg - Y_BITS'(1);
    assign yp1    = out_y_reg + Y_BITS'(1);
    assign addr_a = {out_y_reg[Y_BITS-1:1], ax};
    assign addr_b = {out_y_reg[Y_BITS-1:1], out_x_reg};
    assign addr_c = {ym1[Y_BITS-1:1], out_x_reg};
    assign addr_d = {yp1[Y_BITS-1:1], out_x_reg};
    assign wb_glob = {s1_reg.y[0], s1_reg.y[Y_BITS-1:1], s1_reg.x};

    // A read that lands on the word being written back in the same cycle sees the old
    // word, so the new one is kept aside for it.
    always_comb begin
        fwd_hit_next[0] = wb_we && ({out_y_reg[0], addr_a} == wb_glob);
        fwd_hit_next[1] = wb_we && ({out_y_reg[0], addr_b} == wb_glob);
        fwd_hit_next[2] = wb_we && ({~out_y_reg[0], addr_c} == wb_glob);
        fwd_hit_next[3] = wb_we && ({~out_y_reg[0], addr_d} == wb_glob);
    end

    // Write port: first-plane samples go straight in, later ones are written back
    // from the read stage together with the center of the current plane.
    assign ram_we    = direct_we || wb_we;
    assign ram_sel   = direct_we ? in_y_reg[0] : s1_reg.y[0];
    assign ram_waddr = direct_we ? {in_y_reg[Y_BITS-1:1], in_x_reg}
                                 : {s1_reg.y[Y_BITS-1:1], s1_reg.x};
    assign ram_wdata = direct_we ? {s_sample, s_sample} : wb_word;

    vcdg_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_DEPTH)) u_ram_even (
        .aclk    (aclk),
        .we      (ram_we && !ram_sel),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (accept && gives_out),
        .raddr_a (out_y_reg[0] ? addr_c : addr_a),
        .raddr_b (out_y_reg[0] ? addr_d : addr_b),
        .rdata_a (r0a),
        .rdata_b (r0b)
    );

    vcdg_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_DEPTH)) u_ram_odd (
        .aclk    (aclk),
        .we      (ram_we && ram_sel),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (accept && gives_out),
        .raddr_a (out_y_reg[0] ? addr_a : addr_c),
        .raddr_b (out_y_reg[0] ? addr_b : addr_d),
        .rdata_a (r1a),
        .rdata_b (r1b)
    );

    // Read stage: sort the RAM data back into neighbor words and build the gradients.
    always_comb begin
        w_a = fwd_hit_reg[0] ? fwd_word_reg : (s1_reg.y[0] ? r1a : r0a);
        w_b = fwd_hit_reg[1] ? fwd_word_reg : (s1_reg.y[0] ? r1b : r0b);
        w_c = fwd_hit_reg[2] ? fwd_word_reg : (s1_reg.y[0] ? r0a : r1a);
        w_d = fwd_hit_reg[3] ? fwd_word_reg : (s1_reg.y[0] ? r0b : r1b);

        center = plane_half(w_b, s1_reg.z[0]);
        px = s1_reg.has_px ? plane_half(w_a, s1_reg.z[0]) : '0;
        mx = s1_reg.has_mx ? prev_center_reg : '0;
        py = s1_reg.has_py ? plane_half(w_d, s1_reg.z[0]) : '0;
        my = s1_reg.has_my ? plane_half(w_c, s1_reg.z[0]) : '0;
        mz = s1_reg.has_mz ? plane_half(w_b, ~s1_reg.z[0]) : '0;

        gx = {1'b0, px} - {1'b0, mx};
        gy = {1'b0, py} - {1'b0, my};
        gz = {1'b0, s1_reg.pz} - {1'b0, mz};

        // The new sample replaces the older plane; the current plane's half stays.
        wb_word = s1_reg.z[0] ? {center, s1_reg.pz} : {s1_reg.pz, center};
    end

    always_comb begin
        s1_next.wr     = push_ok;
        s1_next.x      = out_x_reg;
        s1_next.y      = out_y_reg;
        s1_next.z      = out_z_reg;
        s1_next.last   = out_end;
        s1_next.has_mx = (out_x_reg != '0);
        s1_next.has_px = !out_x_last;
        s1_next.has_my = (out_y_reg != '0);
        s1_next.has_py = !out_y_last;
        s1_next.has_mz = (out_z_reg != '0);
        s1_next.pz     = push_ok ? s_sample : '0;
    end

    // Register values clamped to their legal range.
    always_comb begin
        cfg_w9  = cfg_data[WIDTH_CFG_BITS-1:0];
        cfg_d11 = cfg_data[DEPTH_CFG_BITS-1:0];
        if (cfg_w9 == '0) begin
            cfg_w9 = WIDTH_CFG_BITS'(1);
        end else if (cfg_w9 > WIDTH_CFG_BITS'(MAX_WIDTH)) begin
            cfg_w9 = WIDTH_CFG_BITS'(MAX_WIDTH);
        end
        if (cfg_d11 == '0) begin
            cfg_d11 = DEPTH_CFG_BITS'(1);
        end else if (cfg_d11 > DEPTH_CFG_BITS'(MAX_DEPTH)) begin
            cfg_d11 = DEPTH_CFG_BITS'(MAX_DEPTH);
        end
    end

    // Control state: configuration and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_CFG_BITS'(MAX_WIDTH);
            height_reg  <= WIDTH_CFG_BITS'(MAX_HEIGHT);
            depth_reg   <= DEPTH_CFG_BITS'(256);
            in_x_reg    <= '0;
            in_y_reg    <= '0;
            in_z_reg    <= '0;
            in_done_reg <= 1'b0;
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            out_z_reg   <= '0;
        end else if (cfg_hit && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                                 cfg_index == CFG_DEPTH)) begin
            unique case (cfg_index)
                CFG_WIDTH: begin
                    width_reg <= cfg_w9;
                end
                CFG_HEIGHT: begin
                    height_reg <= (cfg_w9 > WIDTH_CFG_BITS'(MAX_HEIGHT)) ?
                                  WIDTH_CFG_BITS'(MAX_HEIGHT) : cfg_w9;
                end
                default: begin
                    depth_reg <= cfg_d11;
                end
            endcase
            in_x_reg    <= '0;
            in_y_reg    <= '0;
            in_z_reg    <= '0;
            in_done_reg <= 1'b0;
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            out_z_reg   <= '0;
        end else if (accept) begin
            if (push_ok) begin
                if (in_x_last) begin
                    in_x_reg <= '0;
                    if (in_y_last) begin
                        in_y_reg <= '0;
                        if (in_z_last) begin
                            in_z_reg    <= '0;
                            in_done_reg <= 1'b1;
                        end else begin
                            in_z_reg <= in_z_reg + Z_BITS'(1);
                        end
                    end else begin
                        in_y_reg <= in_y_reg + Y_BITS'(1);
                    end
                end else begin
                    in_x_reg <= in_x_reg + X_BITS'(1);
                end
            end
            if (gives_out) begin
                if (out_x_last) begin
                    out_x_reg <= '0;
                    if (out_y_last) begin
                        out_y_reg <= '0;
                        if (out_z_last) begin
                            out_z_reg <= '0;
                        end else begin
                            out_z_reg <= out_z_reg + Z_BITS'(1);
                        end
                    end else begin
                        out_y_reg <= out_y_reg + Y_BITS'(1);
                    end
                end else begin
                    out_x_reg <= out_x_reg + X_BITS'(1);
                end
            end
            // The final drain closes the volume; the next push starts a new one.
            if (drain_ok && out_end) begin
                in_done_reg <= 1'b0;
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= gives_out;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept && gives_out) begin
            s1_reg       <= s1_next;
            fwd_hit_reg  <= fwd_hit_next;
            fwd_word_reg <= wb_word;
        end
        if (s1_advance) begin
            prev_center_reg <= center;
            m_grad_x_reg    <= gx;
            m_grad_y_reg    <= gy;
            m_grad_z_reg    <= gz;
            m_pos_x_reg     <= s1_reg.x;
            m_pos_y_reg     <= s1_reg.y;
            m_pos_z_reg     <= s1_reg.z;
            m_last_reg      <= s1_reg.last;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_grad_x = $signed(m_grad_x_reg);
    assign m_grad_y = $signed(m_grad_y_reg);
    assign m_grad_z = $signed(m_grad_z_reg);
    assign m_pos_x  = m_pos_x_reg;
    assign m_pos_y  = m_pos_y_reg;
    assign m_pos_z  = m_pos_z_reg;
    assign m_last   = m_last_reg;

`ifndef SYNTHESIS
    // The two write sources belong to different phases of a volume.
    assert property (@(posedge aclk) disable iff (!aresetn) !(direct_we && wb_we))
        else $error("first-plane write and write-back in the same cycle");

    // Every item that produces a result enters the read stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && gives_out |=> s1_valid_reg)
        else $error("result item lost before the read stage");

    // A register write restarts the volume.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                    cfg_index == CFG_DEPTH)
        |=> !in_done_reg && in_x_reg == '0 && out_x_reg == '0 && out_z_reg == '0)
        else $error("volume not restarted by a register write");

    // The final result of a volume sits at the far corner; the check covers its x position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> ({1'b0, m_pos_x_reg} == width_reg - WIDTH_CFG_BITS'(1)))
        else $error("last flag away from the end of a row");
`endif

endmodule

// ----- tb/sv/vcdg_checker.sv -----
// Checker for the volume gradient block: predicts each result and compares it with the output.
module vcdg_checker import vcdg_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_operation,
    input  logic [SAMPLE_BITS-1:0]      s_sample,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [GRAD_BITS-1:0] m_grad_x,
    input  logic signed [GRAD_BITS-1:0] m_grad_y,
    input  logic signed [GRAD_BITS-1:0] m_grad_z,
    input  logic [X_BITS-1:0]           m_pos_x,
    input  logic [Y_BITS-1:0]           m_pos_y,
    input  logic [Z_BITS-1:0]           m_pos_z,
    input  logic                        m_last,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,
    output int                          fail_count,
    output int                          pending
);

    localparam int PLANE_SLOTS = MAX_WIDTH * MAX_HEIGHT;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] gx;
        logic signed [GRAD_BITS-1:0] gy;
        logic signed [GRAD_BITS-1:0] gz;
        logic [X_BITS-1:0]           px;
        logic [Y_BITS-1:0]           py;
        logic [Z_BITS-1:0]           pz;
        logic                        last;
    } gradient_t;

    logic [SAMPLE_BITS-1:0] voxel_store [0:2*PLANE_SLOTS-1];
    gradient_t              gradient_q[$];
    int unsigned            vol_w, vol_h, vol_d, pushed, emitted;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        int unsigned r;
        r = (v < 1) ? 1 : ((v > hi) ? hi : v);
        return r;
    endfunction

    function automatic int signed voxel_at(int unsigned x, int unsigned y, int unsigned z);
        int signed r;
        r = voxel_store[(z % 2) * PLANE_SLOTS + y * MAX_WIDTH + x];
        return r;
    endfunction

    // Gradient of voxel number n; next_z is the sample one plane further on (zero past the end).
    function automatic gradient_t gradient_of(int unsigned n, int signed next_z);
        gradient_t   g;
        int unsigned x, y, z, total;
        int signed   mx, nx, my, ny, mz;
        total = vol_w * vol_h * vol_d;
        x = n % vol_w;
        y = (n / vol_w) % vol_h;
        z = (n / vol_w) / vol_h;
        mx = (x > 0) ? voxel_at(x - 1, y, z) : 0;
        nx = (x + 1 < vol_w) ? voxel_at(x + 1, y, z) : 0;
        my = (y > 0) ? voxel_at(x, y - 1, z) : 0;
        ny = (y + 1 < vol_h) ? voxel_at(x, y + 1, z) : 0;
        mz = (z > 0) ? voxel_at(x, y, z - 1) : 0;
        g.gx = GRAD_BITS'(nx - mx);
        g.gy = GRAD_BITS'(ny - my);
        g.gz = GRAD_BITS'(next_z - mz);
        g.px = X_BITS'(x);
        g.py = Y_BITS'(y);
        g.pz = Z_BITS'(z);
        g.last = (n + 1 == total);
        return g;
    endfunction

    assign pending = gradient_q.size();

    always @(posedge aclk) begin
        gradient_t   want;
        int unsigned plane, total, x, y, z;
        if (!aresetn) begin
            vol_w = 256;
            vol_h = 256;
            vol_d = 256;
            pushed = 0;
            emitted = 0;
            fail_count = 0;
            gradient_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (gradient_q.size() == 0) begin
                    $error("unexpected result at x=%0d y=%0d z=%0d", m_pos_x, m_pos_y, m_pos_z);
                    fail_count++;
                end else begin
                    want = gradient_q.pop_front();
                    if (m_grad_x !== want.gx) begin
                        $error("grad_x expected %0d actual %0d", want.gx, m_grad_x);
                        fail_count++;
                    end
                    if (m_grad_y !== want.gy) begin
                        $error("grad_y expected %0d actual %0d", want.gy, m_grad_y);
                        fail_count++;
                    end
                    if (m_grad_z !== want.gz) begin
                        $error("grad_z expected %0d actual %0d", want.gz, m_grad_z);
                        fail_count++;
                    end
                    if (m_pos_x !== want.px) begin
                        $error("pos_x expected %0d actual %0d", want.px, m_pos_x);
                        fail_count++;
                    end
                    if (m_pos_y !== want.py) begin
                        $error("pos_y expected %0d actual %0d", want.py, m_pos_y);
                        fail_count++;
                    end
                    if (m_pos_z !== want.pz) begin
                        $error("pos_z expected %0d actual %0d", want.pz, m_pos_z);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, m_last);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WIDTH) vol_w = clamp_dim(cfg_data[8:0], MAX_WIDTH);
                else if (cfg_index == CFG_HEIGHT) vol_h = clamp_dim(cfg_data[8:0], MAX_HEIGHT);
                else if (cfg_index == CFG_DEPTH) vol_d = clamp_dim(cfg_data, MAX_DEPTH);
                if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT || cfg_index == CFG_DEPTH) begin
                    pushed = 0;
                    emitted = 0;
                end
            end
            if (s_valid && s_ready) begin
                plane = vol_w * vol_h;
                total = plane * vol_d;
                if (s_operation == OP_PUSH) begin
                    if (pushed < total) begin
                        if (pushed >= plane) begin
                            gradient_q.push_back(gradient_of(emitted, s_sample));
                            emitted++;
                        end
                        x = pushed % vol_w;
                        y = (pushed / vol_w) % vol_h;
                        z = (pushed / vol_w) / vol_h;
                        voxel_store[(z % 2) * PLANE_SLOTS + y * MAX_WIDTH + x] = s_sample;
                        pushed++;
                    end
                end else if (pushed == total && emitted < total) begin
                    gradient_q.push_back(gradient_of(emitted, 0));
                    emitted++;
                    if (emitted == total) begin
                        pushed = 0;
                        emitted = 0;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_volume_central_difference_gradient.sv -----
// Top of the volume gradient testbench: clock, reset, stimulus, watchdog and verdict.
module tb_volume_central_difference_gradient;
    import vcdg_pkg::*;

    // Index 3 names no register; the block must ignore a write to it.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_operation;
    logic [SAMPLE_BITS-1:0]      s_sample;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [GRAD_BITS-1:0] m_grad_x;
    logic signed [GRAD_BITS-1:0] m_grad_y;
    logic signed [GRAD_BITS-1:0] m_grad_z;
    logic [X_BITS-1:0]           m_pos_x;
    logic [Y_BITS-1:0]           m_pos_y;
    logic [Z_BITS-1:0]           m_pos_z;
    logic                        m_last;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;
    int                          fail_count;
    int                          pending;

    // Random idling on both sides is switched off for the final stretch of the run.
    bit gaps_on;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit long_hold_req;
    int items_sent;

    volume_central_difference_gradient i_dut (.*);

    vcdg_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver side: short random stalls, plus one long hold-off when asked.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // The watchdog ends the run when no channel has moved an item for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Offers one item and returns at the edge where it is taken. Valid is only lowered for
    // an idle burst, so back-to-back items keep it high without a glitch.
    task automatic send_item(input logic op, input logic [SAMPLE_BITS-1:0] value);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_sample    <= value;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Waits until every expected result has come, then lets the pipeline settle, so the
    // block is idle before a register write.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Samples lean toward the extremes so that the largest differences show up often.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            default: v = SAMPLE_BITS'($urandom);
        endcase
        return v;
    endfunction

    // Writes the three dimensions, then pushes a whole volume and drains its final plane.
    // The effective sizes are reckoned here so that noise items can be placed where the block
    // must ignore them: early drains during the push phase, surplus pushes after it.
    task automatic run_volume(input int raw_w, input int raw_h, input int raw_d,
                              input int noise_pct);
        int w, h, d, total;
        w = (raw_w & 9'h1FF) < 1 ? 1 : ((raw_w & 9'h1FF) > MAX_WIDTH ? MAX_WIDTH : raw_w & 9'h1FF);
        h = (raw_h & 9'h1FF) < 1 ? 1 : ((raw_h & 9'h1FF) > MAX_HEIGHT ? MAX_HEIGHT : raw_h & 9'h1FF);
        d = (raw_d & 11'h7FF) < 1 ? 1 : ((raw_d & 11'h7FF) > MAX_DEPTH ? MAX_DEPTH : raw_d & 11'h7FF);
        total = w * h * d;
        wait_idle();
        write_reg(CFG_DEPTH, CFG_DATA_BITS'(raw_d));
        write_reg(CFG_WIDTH, CFG_DATA_BITS'(raw_w));
        write_reg(CFG_HEIGHT, CFG_DATA_BITS'(raw_h));
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_item(OP_DRAIN, pick_sample());
            send_item(OP_PUSH, pick_sample());
        end
        if ($urandom_range(1, 100) <= 3 * noise_pct)
            send_item(OP_PUSH, pick_sample());
        for (int i = 0; i < w * h; i++)
            send_item(OP_DRAIN, pick_sample());
        // With the volume done and counters cleared, a lone drain has nothing to give.
        if ($urandom_range(1, 100) <= noise_pct)
            send_item(OP_DRAIN, pick_sample());
    endtask

    initial begin
        int vols;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;
        items_sent    = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_PUSH;
        s_sample    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_WIDTH;
        cfg_data    = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. A write to the unused index must change nothing.
        write_reg(CFG_UNUSED, '1);
        // Zero sizes clamp to one voxel: the single result leaves only on the drain.
        run_volume(0, 0, 0, 0);
        // A 2x2x2 volume with an early drain, a surplus push and all-ones/all-zeros samples.
        wait_idle();
        write_reg(CFG_WIDTH, CFG_DATA_BITS'(2));
        write_reg(CFG_HEIGHT, CFG_DATA_BITS'(2));
        write_reg(CFG_DEPTH, CFG_DATA_BITS'(2));
        send_item(OP_DRAIN, '1);
        for (int i = 0; i < 8; i++)
            send_item(OP_PUSH, (i % 3 == 0) ? '1 : '0);
        send_item(OP_PUSH, '1);
        for (int i = 0; i < 4; i++)
            send_item(OP_DRAIN, '0);
        // A register write in the middle of a volume restarts it; the RAMs keep their data.
        wait_idle();
        write_reg(CFG_WIDTH, CFG_DATA_BITS'(3));
        for (int i = 0; i < 10; i++)
            send_item(OP_PUSH, pick_sample());
        wait_idle();
        write_reg(CFG_HEIGHT, CFG_DATA_BITS'(2));

        // Width and height above the limit clamp to 256. A partial volume of 260 pushes
        // already gives the first results, which it could not if 511 were taken as is.
        wait_idle();
        write_reg(CFG_DEPTH, CFG_DATA_BITS'(2));
        write_reg(CFG_HEIGHT, CFG_DATA_BITS'(1));
        write_reg(CFG_WIDTH, CFG_DATA_BITS'(511));
        for (int i = 0; i < 260; i++)
            send_item(OP_PUSH, pick_sample());
        wait_idle();
        write_reg(CFG_WIDTH, CFG_DATA_BITS'(1));
        write_reg(CFG_HEIGHT, CFG_DATA_BITS'(511));
        for (int i = 0; i < 260; i++)
            send_item(OP_PUSH, pick_sample());

        // Random part. The long receiver hold-off falls on the first volume, and the
        // sender once pauses until the block has nothing left to give.
        vols = 0;
        while (items_sent < 780) begin
            if (vols == 0)
                long_hold_req = 1'b1;
            if (vols == 1) begin
                send_item(OP_PUSH, pick_sample());
                wait_idle();
            end
            if (vols == 0)
                run_volume(12, 4, 2, 2);
            else if ($urandom_range(0, 9) == 0)
                run_volume($urandom_range(0, 511), 1, $urandom_range(1, 3), 4);
            else
                run_volume($urandom_range(1, 12), $urandom_range(1, 8),
                           $urandom_range(1, 6), 4);
            vols++;
        end

        // The deepest volume closes the run, with no idling on either side.
        gaps_on = 1'b0;
        run_volume(1, 1, 2047, 0);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- volume_central_difference_gradient.f -----
hdl/vcdg_pkg.sv
hdl/vcdg_ram.sv
hdl/volume_central_difference_gradient.sv
tb/sv/vcdg_checker.sv
tb/sv/tb_volume_central_difference_gradient.sv
